// ----- design/tkpl_pkg.sv -----
// Shared types, constants and codes for the touch keypad PIN lock.
`default_nettype none
package tkpl_pkg;

  // Keypad geometry and sizing.
  localparam int PIN_LENGTH    = 4;
  localparam int SCREEN_WIDTH  = 800;
  localparam int SCREEN_HEIGHT = 480;
  localparam int NUM_PIN_REGS  = 4;
  localparam int RAW_SCALE_SH  = 12;  // divide by 4096
  localparam int BOX_HALF_W    = 50;
  localparam int BOX_HALF_H    = 40;
  localparam int NUM_ROWS      = 4;
  localparam int NUM_COLS      = 3;

  // Field widths.
  localparam int BYTE_W  = 8;
  localparam int RAW_W   = 16;
  localparam int X_W     = 13;
  localparam int Y_W     = 12;
  localparam int KEY_W   = 4;
  localparam int DIGIT_W = 4;
  localparam int COUNT_W = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;
  localparam int PROD_X_W = RAW_W + $clog2(SCREEN_WIDTH + 1);
  localparam int PROD_Y_W = RAW_W + $clog2(SCREEN_HEIGHT + 1);

  // Stream codes.
  localparam logic [BYTE_W-1:0] BYTE_DROP   = 8'h80;
  localparam logic [BYTE_W-1:0] BYTE_REPORT = 8'h81;
  localparam logic [1:0] DROP_LEN = 2'd3;

  // Report phases: 0 waits for a report start, 1..3 collect bytes, 4 takes the last.
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LAST = 3'd4;

  // Key codes.
  localparam logic [KEY_W-1:0] KEY_MAX_DIGIT = 4'd9;
  localparam logic [KEY_W-1:0] KEY_CLEAR     = 4'd10;
  localparam logic [KEY_W-1:0] KEY_ENTER     = 4'd11;
  localparam logic [KEY_W-1:0] KEY_NONE      = 4'd12;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

  localparam int COL_CENTRE [NUM_COLS] = '{275, 400, 525};
  localparam int ROW_CENTRE [NUM_ROWS] = '{96, 192, 288, 384};
  localparam logic [KEY_W-1:0] GRID_KEY [NUM_ROWS][NUM_COLS] = '{
    '{4'd1, 4'd2, 4'd3},
    '{4'd4, 4'd5, 4'd6},
    '{4'd7, 4'd8, 4'd9},
    '{KEY_CLEAR, 4'd0, KEY_ENTER}
  };

  // PIN register reset values.
  localparam logic [DIGIT_W-1:0] PIN_RESET [NUM_PIN_REGS] = '{4'd5, 4'd2, 4'd8, 4'd0};

  // Queue between parser and keypad logic.
  localparam int MID_DEPTH = 4;
  localparam int MID_PTR_W = $clog2(MID_DEPTH);
  localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);

  typedef enum logic [2:0] {
    OUT_DIGIT    = 3'd0,
    OUT_IGNORED  = 3'd1,
    OUT_CLEARED  = 3'd2,
    OUT_UNLOCKED = 3'd3,
    OUT_REJECTED = 3'd4
  } outcome_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
  } report_t;

  typedef struct packed {
    logic [X_W-1:0]     touch_x;
    logic [Y_W-1:0]     touch_y;
    logic [KEY_W-1:0]   key_hit;
    outcome_t           outcome;
    logic [COUNT_W-1:0] digits_entered;
  } result_t;

endpackage
`default_nettype wire

// ----- design/tkpl_front.sv -----
// Byte parser: drop windows, report framing and raw coordinate assembly.
`default_nettype none
module tkpl_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        byte_valid,
  input  wire logic [tkpl_pkg::BYTE_W-1:0] byte_in,
  output tkpl_pkg::report_t                rep,
  output logic                             rep_push
);

  logic [1:0]                  skip_r, skip_nxt;
  logic [2:0]                  phase_r, phase_nxt;
  logic [tkpl_pkg::BYTE_W-1:0] bytes_r [3];
  logic [tkpl_pkg::BYTE_W-1:0] bytes_nxt [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r  <= '0;
      phase_r <= tkpl_pkg::PH_IDLE;
      for (int i = 0; i < 3; i++) begin
        bytes_r[i] <= '0;
      end
    end else begin
      skip_r  <= skip_nxt;
      phase_r <= phase_nxt;
      bytes_r <= bytes_nxt;
    end
  end

  always_comb begin
    skip_nxt  = skip_r;
    phase_nxt = phase_r;
    bytes_nxt = bytes_r;
    rep_push  = 1'b0;
    rep.raw_y = tkpl_pkg::RAW_W'(bytes_r[0]) + (tkpl_pkg::RAW_W'(bytes_r[1]) << 7);
    rep.raw_x = tkpl_pkg::RAW_W'(bytes_r[2]) + (tkpl_pkg::RAW_W'(byte_in) << 7);
    if (byte_valid) begin
      if (byte_in == tkpl_pkg::BYTE_DROP) begin
        skip_nxt = tkpl_pkg::DROP_LEN;
      end else if (skip_r != 2'd0) begin
        skip_nxt = skip_r - 2'd1;
      end else if (phase_r == tkpl_pkg::PH_IDLE) begin
        if (byte_in == tkpl_pkg::BYTE_REPORT) begin
          phase_nxt = 3'd1;
        end
      end else if (phase_r < tkpl_pkg::PH_LAST) begin
        bytes_nxt[2'(phase_r - 3'd1)] = byte_in;
        phase_nxt = phase_r + 3'd1;
      end else begin
        phase_nxt = tkpl_pkg::PH_IDLE;
        rep_push  = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/tkpl_fifo.sv -----
// Short report queue between the parser and the keypad logic.
`default_nettype none
module tkpl_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire tkpl_pkg::report_t push_data,
  input  wire logic          pop,
  output tkpl_pkg::report_t  pop_data,
  output logic               full,
  output logic               empty
);

  tkpl_pkg::report_t                 mem_r [tkpl_pkg::MID_DEPTH];
  logic [tkpl_pkg::MID_PTR_W-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [tkpl_pkg::MID_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                              do_push, do_pop;

  assign full     = (cnt_r == tkpl_pkg::MID_CNT_W'(tkpl_pkg::MID_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_r];

  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- design/tkpl_back.sv -----
// Keypad logic: scale, box lookup, digit entry, PIN check and result buffer.
`default_nettype none
module tkpl_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire tkpl_pkg::report_t               rep,
  input  wire logic                            rep_empty,
  output logic                                 rep_pop,
  input  wire logic                            cfg_we,
  input  wire logic [tkpl_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [tkpl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                            res_pop,
  output tkpl_pkg::result_t                    res,
  output logic                                 res_empty
);

  // Scale stage.
  logic                      s1_valid_r;
  logic [tkpl_pkg::X_W-1:0]  s1_x_r;
  logic [tkpl_pkg::Y_W-1:0]  s1_y_r;
  logic [tkpl_pkg::PROD_X_W-1:0] prod_x;
  logic [tkpl_pkg::PROD_Y_W-1:0] prod_y;
  logic                      s1_go, s1_load;

  // Keypad state.
  logic [tkpl_pkg::DIGIT_W-1:0] pin_r [tkpl_pkg::NUM_PIN_REGS];
  logic [tkpl_pkg::DIGIT_W-1:0] dig_r [tkpl_pkg::PIN_LENGTH];
  logic [tkpl_pkg::DIGIT_W-1:0] dig_nxt [tkpl_pkg::PIN_LENGTH];
  logic [tkpl_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [tkpl_pkg::KEY_W-1:0]   key;
  logic                         found, match;
  tkpl_pkg::outcome_t           outcome;
  tkpl_pkg::result_t            new_res;

  // Two-entry result buffer.
  tkpl_pkg::result_t ob_r [2];
  logic              ob_wr_r, ob_rd_r;
  logic [1:0]        ob_cnt_r, ob_cnt_nxt;
  logic              ob_full, ob_pop;

  assign ob_full   = (ob_cnt_r == 2'd2);
  assign res_empty = (ob_cnt_r == 2'd0);
  assign ob_pop    = res_pop && !res_empty;
  assign res       = ob_r[ob_rd_r];

  assign s1_go   = s1_valid_r && !ob_full;
  assign s1_load = !s1_valid_r || s1_go;
  assign rep_pop = s1_load && !rep_empty;

  assign prod_x = tkpl_pkg::PROD_X_W'(rep.raw_x) * tkpl_pkg::PROD_X_W'(tkpl_pkg::SCREEN_WIDTH);
  assign prod_y = tkpl_pkg::PROD_Y_W'(rep.raw_y) * tkpl_pkg::PROD_Y_W'(tkpl_pkg::SCREEN_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= !rep_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (rep_pop) begin
      s1_x_r <= tkpl_pkg::X_W'(prod_x >> tkpl_pkg::RAW_SCALE_SH);
      s1_y_r <= tkpl_pkg::Y_W'(prod_y >> tkpl_pkg::RAW_SCALE_SH);
    end
  end

  // Box lookup, first match in row order.
  always_comb begin
    key   = tkpl_pkg::KEY_NONE;
    found = 1'b0;
    for (int r = 0; r < tkpl_pkg::NUM_ROWS; r++) begin
      for (int c = 0; c < tkpl_pkg::NUM_COLS; c++) begin
        if (!found &&
            ({1'b0, s1_x_r} + 14'(tkpl_pkg::BOX_HALF_W) >= 14'(tkpl_pkg::COL_CENTRE[c])) &&
            ({1'b0, s1_x_r} <= 14'(tkpl_pkg::COL_CENTRE[c] + tkpl_pkg::BOX_HALF_W)) &&
            ({1'b0, s1_y_r} + 13'(tkpl_pkg::BOX_HALF_H) >= 13'(tkpl_pkg::ROW_CENTRE[r])) &&
            ({1'b0, s1_y_r} <= 13'(tkpl_pkg::ROW_CENTRE[r] + tkpl_pkg::BOX_HALF_H))) begin
          key   = tkpl_pkg::GRID_KEY[r][c];
          found = 1'b1;
        end
      end
    end
  end

  // Positions past the PIN registers compare against zero.
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < tkpl_pkg::PIN_LENGTH; i++) begin
      if (i < tkpl_pkg::NUM_PIN_REGS) begin
        if (dig_r[i] != pin_r[i % tkpl_pkg::NUM_PIN_REGS]) begin
          match = 1'b0;
        end
      end else if (dig_r[i] != '0) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    dig_nxt   = dig_r;
    count_nxt = count_r;
    outcome   = tkpl_pkg::OUT_IGNORED;
    if (key <= tkpl_pkg::KEY_MAX_DIGIT) begin
      for (int i = 0; i < tkpl_pkg::PIN_LENGTH; i++) begin
        if (count_r == tkpl_pkg::COUNT_W'(i)) begin
          dig_nxt[i] = key;
        end
      end
      if (count_r != tkpl_pkg::COUNT_MAX) begin
        count_nxt = count_r + 1'b1;
      end
      outcome = tkpl_pkg::OUT_DIGIT;
    end else if (key == tkpl_pkg::KEY_CLEAR) begin
      count_nxt = '0;
      outcome   = tkpl_pkg::OUT_CLEARED;
    end else if (key == tkpl_pkg::KEY_ENTER) begin
      count_nxt = '0;
      outcome   = match ? tkpl_pkg::OUT_UNLOCKED : tkpl_pkg::OUT_REJECTED;
    end
    new_res.touch_x        = s1_x_r;
    new_res.touch_y        = s1_y_r;
    new_res.key_hit        = key;
    new_res.outcome        = outcome;
    new_res.digits_entered = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < tkpl_pkg::PIN_LENGTH; i++) begin
        dig_r[i] <= '0;
      end
    end else if (s1_go) begin
      count_r <= count_nxt;
      dig_r   <= dig_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_r <= tkpl_pkg::PIN_RESET;
    end else if (cfg_we && (cfg_idx < tkpl_pkg::CFG_IDX_W'(tkpl_pkg::NUM_PIN_REGS))) begin
      pin_r[2'(cfg_idx)] <= cfg_wdata;
    end
  end

  always_comb begin
    ob_cnt_nxt = ob_cnt_r;
    if (s1_go && !ob_pop) begin
      ob_cnt_nxt = ob_cnt_r + 2'd1;
    end else if (ob_pop && !s1_go) begin
      ob_cnt_nxt = ob_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wr_r  <= 1'b0;
      ob_rd_r  <= 1'b0;
      ob_cnt_r <= '0;
    end else begin
      ob_cnt_r <= ob_cnt_nxt;
      if (s1_go) begin
        ob_wr_r <= !ob_wr_r;
      end
      if (ob_pop) begin
        ob_rd_r <= !ob_rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      ob_r[ob_wr_r] <= new_res;
    end
  end

endmodule
`default_nettype wire

// ----- design/touch_keypad_pin_lock.sv -----
// Top level of the touch keypad PIN lock: parser, report queue and keypad logic.
// Throughput: one byte per cycle; in_full rises only when the report queue backs up.
// Path: a report's raw coordinates are registered in the report queue, then in the scale
//   stage, then in the result buffer, which presents them to the result side.
// Reset: synchronous, clears the parser, queues, digit count and stored digits,
//   and loads the PIN registers with 5, 2, 8, 0.
`default_nettype none
module touch_keypad_pin_lock (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Byte requests from the touch controller link.
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire logic [tkpl_pkg::BYTE_W-1:0]     in_rx_byte,
  // Result requests, one per completed release report.
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output logic [tkpl_pkg::X_W-1:0]             out_touch_x,
  output logic [tkpl_pkg::Y_W-1:0]             out_touch_y,
  output logic [tkpl_pkg::KEY_W-1:0]           out_key_hit,
  output logic [2:0]                           out_outcome,
  output logic [tkpl_pkg::COUNT_W-1:0]         out_digits_entered,
  // PIN register writes.
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tkpl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tkpl_pkg::CFG_DATA_W-1:0] cfg_data
);

  tkpl_pkg::report_t front_rep, mid_rep;
  tkpl_pkg::result_t res;
  logic              front_push, mid_full, mid_empty, mid_pop, byte_acc;

  // Hold off bytes while the report queue is full; the parser never stalls otherwise.
  assign in_full   = mid_full;
  assign byte_acc  = in_push && !in_full;
  // Configuration is always taken.
  assign cfg_ready = 1'b1;

  tkpl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_acc),
    .byte_in    (in_rx_byte),
    .rep        (front_rep),
    .rep_push   (front_push)
  );

  // Decouple the parser from the keypad logic so each stalls on its own.
  tkpl_fifo u_mid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_push),
    .push_data (front_rep),
    .pop       (mid_pop),
    .pop_data  (mid_rep),
    .full      (mid_full),
    .empty     (mid_empty)
  );

  tkpl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rep       (mid_rep),
    .rep_empty (mid_empty),
    .rep_pop   (mid_pop),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .res_pop   (out_pop),
    .res       (res),
    .res_empty (out_empty)
  );

  // Present the oldest buffered result.
  assign out_touch_x        = res.touch_x;
  assign out_touch_y        = res.touch_y;
  assign out_key_hit        = res.key_hit;
  assign out_outcome        = res.outcome;
  assign out_digits_entered = res.digits_entered;

endmodule
`default_nettype wire

// ----- sim/touch_keypad_pin_lock_test.sv -----
// Self-checking testbench for the touch keypad PIN lock: byte streams in, key presses checked.
module touch_keypad_pin_lock_test;
  import tkpl_pkg::*;

  // Keypad geometry, kept apart from the package tables.
  localparam int BOX_DX      = 50;
  localparam int BOX_DY      = 40;
  localparam int DROP_SPAN   = 3;     // bytes swallowed after a drop marker
  localparam int COUNT_CAP   = 15;
  localparam int LATENCY_PAD = 4;     // extra settle wait once the last pending press is popped
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_BYTES = 180;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIN_0 = 3'd0,
    REG_PIN_1 = 3'd1,
    REG_PIN_2 = 3'd2,
    REG_PIN_3 = 3'd3
  } pin_reg_e;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_push    = 1'b0;
  logic [BYTE_W-1:0]     in_rx_byte = '0;
  logic                  in_full;
  logic                  out_empty;
  logic                  out_pop    = 1'b0;
  logic [X_W-1:0]        out_touch_x;
  logic [Y_W-1:0]        out_touch_y;
  logic [KEY_W-1:0]      out_key_hit;
  logic [2:0]            out_outcome;
  logic [COUNT_W-1:0]    out_digits_entered;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // Keypad state as predicted from the accepted byte stream.
  logic [1:0]         drop_left;
  logic [2:0]         report_phase;
  logic [BYTE_W-1:0]  report_buf [3];
  logic [DIGIT_W-1:0] typed_digit [PIN_LENGTH];
  logic [COUNT_W-1:0] digit_cnt;
  logic [DIGIT_W-1:0] pin_code [NUM_PIN_REGS];

  // Key presses predicted but not yet popped, oldest first.
  result_t pending_press [$];

  // Idle and stall rates in percent, set per phase.
  int send_idle  = 0;
  int recv_stall = 0;
  bit holding    = 1'b0;
  event hold_off_start;

  int n_errors     = 0;
  int bytes_sent   = 0;
  int n_checked    = 0;
  int n_unlocks    = 0;
  int n_rejects    = 0;
  int n_clears     = 0;
  int reg_writes   = 0;
  int full_stalls  = 0;
  int quiet_cycles = 0;

  touch_keypad_pin_lock i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_rx_byte         (in_rx_byte),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_touch_x        (out_touch_x),
    .out_touch_y        (out_touch_y),
    .out_key_hit        (out_key_hit),
    .out_outcome        (out_outcome),
    .out_digits_entered (out_digits_entered),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Box centres: three columns 125 apart, four rows 96 apart.
  function automatic int col_x(input int c);
    return 275 + 125 * c;
  endfunction

  function automatic int row_y(input int r);
    return 96 + 96 * r;
  endfunction

  // Rows hold 1 2 3 / 4 5 6 / 7 8 9 / clear 0 enter.
  function automatic logic [KEY_W-1:0] key_of(input int r, input int c);
    if (r == 3) begin
      if (c == 0) return KEY_CLEAR;
      if (c == 1) return 4'd0;
      return KEY_ENTER;
    end
    return KEY_W'(3 * r + c + 1);
  endfunction

  // Walk the boxes in keypad order; the first box containing the point wins.
  function automatic logic [KEY_W-1:0] key_at(input int x, input int y);
    logic [KEY_W-1:0] k;
    k = KEY_NONE;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 3; c++)
        if (k == KEY_NONE && x + BOX_DX >= col_x(c) && x <= col_x(c) + BOX_DX &&
            y + BOX_DY >= row_y(r) && y <= row_y(r) + BOX_DY)
          k = key_of(r, c);
    return k;
  endfunction

  // Advance the predicted keypad by one accepted byte; queue the press it completes.
  task automatic decode_byte(input logic [BYTE_W-1:0] b);
    int raw_x, raw_y, x, y;
    bit hit;
    result_t press;
    if (b == BYTE_DROP) begin
      drop_left = 2'(DROP_SPAN);
    end else if (drop_left != 0) begin
      drop_left = drop_left - 2'd1;
    end else if (report_phase == 0) begin
      if (b == BYTE_REPORT) report_phase = 3'd1;
    end else if (report_phase < 4) begin
      report_buf[report_phase - 1] = b;
      report_phase = report_phase + 3'd1;
    end else begin
      report_phase = 3'd0;
      raw_y = int'(report_buf[0]) + 128 * int'(report_buf[1]);
      raw_x = int'(report_buf[2]) + 128 * int'(b);
      x = raw_x * SCREEN_WIDTH / 4096;
      y = raw_y * SCREEN_HEIGHT / 4096;
      press.key_hit = key_at(x, y);
      if (press.key_hit < KEY_CLEAR) begin
        // Digits past the stored positions only bump the count.
        if (digit_cnt < PIN_LENGTH) typed_digit[digit_cnt[1:0]] = press.key_hit;
        if (digit_cnt != COUNT_CAP) digit_cnt = digit_cnt + 4'd1;
        press.outcome = OUT_DIGIT;
      end else if (press.key_hit == KEY_CLEAR) begin
        digit_cnt = '0;
        press.outcome = OUT_CLEARED;
      end else if (press.key_hit == KEY_ENTER) begin
        // Stale digits from earlier entries take part in the compare.
        hit = 1'b1;
        for (int i = 0; i < PIN_LENGTH; i++)
          if (typed_digit[i] != ((i < NUM_PIN_REGS) ? pin_code[i] : 4'd0)) hit = 1'b0;
        digit_cnt = '0;
        press.outcome = hit ? OUT_UNLOCKED : OUT_REJECTED;
      end else begin
        press.outcome = OUT_IGNORED;
      end
      press.touch_x = x[X_W-1:0];
      press.touch_y = y[Y_W-1:0];
      press.digits_entered = digit_cnt;
      pending_press.push_back(press);
    end
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  task automatic check_press();
    result_t want;
    if (pending_press.size() == 0) begin
      $error("key press popped with none pending: key_hit %0d, outcome %0d",
             out_key_hit, out_outcome);
      n_errors++;
    end else begin
      want = pending_press.pop_front();
      compare_field("touch_x", want.touch_x, out_touch_x);
      compare_field("touch_y", want.touch_y, out_touch_y);
      compare_field("key_hit", want.key_hit, out_key_hit);
      compare_field("outcome", want.outcome, out_outcome);
      compare_field("digits_entered", want.digits_entered, out_digits_entered);
      n_checked++;
      case (want.outcome)
        OUT_UNLOCKED: n_unlocks++;
        OUT_REJECTED: n_rejects++;
        OUT_CLEARED:  n_clears++;
        default: ;
      endcase
    end
  endtask

  // Result side: check every popped request, then decide whether to pop next cycle.
  always @(posedge clk) begin
    if (rst_n && out_pop && out_empty === 1'b0) check_press();
    out_pop <= !holding && ($urandom_range(99) >= recv_stall);
  end

  // Long receiver hold-off, counted here so the sender keeps offering bytes meanwhile.
  always @(hold_off_start) begin
    holding = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding = 1'b0;
  end

  // Watchdog: give up when no request of any kind moves for too long.
  always @(posedge clk) begin
    if ((in_push && in_full === 1'b0) || (out_pop && out_empty === 1'b0) ||
        (cfg_valid && cfg_ready === 1'b1))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (in_push && in_full === 1'b1) full_stalls++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("no request moved for %0d cycles, %0d presses pending",
               STALL_LIMIT, pending_press.size());
      $display("touch_keypad_pin_lock_test: done, errors");
      $finish;
    end
  end

  // Offer one byte, with random idle cycles ahead of it; hold until it is taken.
  task automatic push_byte(input logic [BYTE_W-1:0] b);
    if ($urandom_range(99) < send_idle) begin
      in_push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_push    <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_full !== 1'b0);
    decode_byte(b);
    bytes_sent++;
  endtask

  // Split a raw coordinate into low and high bytes; sometimes carry bit 7 in the low byte.
  function automatic logic [15:0] split_raw(input int raw);
    int lo, hi;
    lo = raw % 128;
    hi = raw / 128;
    if (hi > 0 && lo != 0 && $urandom_range(1) == 1) begin
      lo += 128;
      hi -= 1;
    end
    return {hi[7:0], lo[7:0]};
  endfunction

  task automatic send_report(input int raw_x, input int raw_y);
    logic [15:0] ys, xs;
    ys = split_raw(raw_y);
    xs = split_raw(raw_x);
    push_byte(BYTE_REPORT);
    push_byte(ys[7:0]);
    push_byte(ys[15:8]);
    push_byte(xs[7:0]);
    push_byte(xs[15:8]);
  endtask

  // Offsets favor the exact box edges.
  function automatic int pick_offset(input int half);
    case ($urandom_range(3))
      0: return -half;
      1: return half;
      default: return int'($urandom_range(0, 2 * half)) - half;
    endcase
  endfunction

  // Release report aimed at a key box, or at the margins and gaps for no key.
  task automatic touch_key(input logic [KEY_W-1:0] k);
    int r, c, px, py;
    if (k == KEY_NONE) begin
      case ($urandom_range(3))
        0: begin
          px = $urandom_range(0, 224);
          py = $urandom_range(0, 479);
        end
        1: begin
          px = $urandom_range(326, 349);
          py = $urandom_range(56, 424);
        end
        2: begin
          px = $urandom_range(225, 575);
          py = $urandom_range(137, 151);
        end
        default: begin
          px = $urandom_range(0, 799);
          py = $urandom_range(425, 479);
        end
      endcase
    end else begin
      if (k == KEY_CLEAR) begin
        r = 3;
        c = 0;
      end else if (k == KEY_ENTER) begin
        r = 3;
        c = 2;
      end else if (k == 0) begin
        r = 3;
        c = 1;
      end else begin
        r = (k - 1) / 3;
        c = (k - 1) % 3;
      end
      px = col_x(c) + pick_offset(BOX_DX);
      py = row_y(r) + pick_offset(BOX_DY);
    end
    // Round the raw value up so that scaling lands back on the chosen pixel.
    send_report((px * 4096 + SCREEN_WIDTH - 1) / SCREEN_WIDTH,
                (py * 4096 + SCREEN_HEIGHT - 1) / SCREEN_HEIGHT);
  endtask

  // One code attempt: some digits, right or random, then enter or clear.
  task automatic try_pin(input int right_pct);
    int n;
    bit right;
    right = $urandom_range(99) < right_pct;
    n = ($urandom_range(7) == 0) ? $urandom_range(5, 17) : $urandom_range(0, PIN_LENGTH + 1);
    for (int i = 0; i < n; i++)
      touch_key((right && i < NUM_PIN_REGS && pin_code[i] < KEY_CLEAR) ?
                pin_code[i] : $urandom_range(9));
    if ($urandom_range(4) == 0) touch_key(KEY_CLEAR);
    else touch_key(KEY_ENTER);
  endtask

  task automatic drop_packet();
    push_byte(BYTE_DROP);
    repeat (DROP_SPAN) push_byte($urandom_range(255));
  endtask

  // Drop the input and wait until every predicted press has been popped.
  task automatic settle();
    in_push <= 1'b0;
    while (pending_press.size() != 0) @(posedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  // Leaves valid high so back-to-back writes never lower and raise it in one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx < NUM_PIN_REGS) pin_code[idx[1:0]] = val;
    reg_writes++;
  endtask

  // Load a new code once idle; a stray write to an unused index must change nothing.
  task automatic set_pin(input logic [3:0] d0, d1, d2, d3, input bit stray);
    settle();
    write_reg(REG_PIN_0, d0);
    write_reg(REG_PIN_1, d1);
    write_reg(REG_PIN_2, d2);
    write_reg(REG_PIN_3, d3);
    if (stray) write_reg($urandom_range(NUM_PIN_REGS, 7), $urandom_range(15));
    cfg_valid <= 1'b0;
  endtask

  // All-ones and all-zero reports: largest scaled position and the origin, both no key.
  task automatic test_extremes();
    push_byte(BYTE_REPORT);
    repeat (4) push_byte(8'hFF);
    push_byte(BYTE_REPORT);
    repeat (4) push_byte(8'h00);
  endtask

  // Report start swallowed by a drop window, then a report with a start byte as data
  // and a drop window restarted inside it; it lands on key 0.
  task automatic test_framing();
    push_byte(BYTE_DROP);
    push_byte(BYTE_REPORT);
    push_byte(8'h12);
    push_byte(8'h34);
    push_byte(BYTE_REPORT);
    push_byte(BYTE_REPORT);
    push_byte(BYTE_DROP);
    push_byte(BYTE_REPORT);
    push_byte(BYTE_DROP);
    push_byte(8'h55);
    push_byte(8'h66);
    push_byte(8'h77);
    push_byte(8'h19);
    push_byte(8'h00);
    push_byte(8'h10);
  endtask

  // Code from reset, then a short entry that only unlocks through stale digits.
  task automatic test_default_pin();
    touch_key(4'd5);
    touch_key(4'd2);
    touch_key(4'd8);
    touch_key(4'd0);
    touch_key(KEY_ENTER);
    touch_key(4'd5);
    touch_key(4'd2);
    touch_key(KEY_ENTER);
  endtask

  // Run the count past the stored positions into saturation.
  task automatic test_digit_overflow();
    repeat (COUNT_CAP + 3) touch_key($urandom_range(9));
    touch_key(KEY_ENTER);
  endtask

  task automatic test_key_sweep();
    repeat (3)
      for (int k = 0; k <= KEY_NONE; k++) touch_key(k);
  endtask

  task automatic test_pin_registers();
    set_pin(4'd9, 4'd9, 4'd9, 4'd9, 1'b0);
    repeat (6) try_pin(70);
    set_pin(4'd0, 4'd0, 4'd0, 4'd0, 1'b1);
    repeat (6) try_pin(70);
    // Register values above nine can never match a key.
    set_pin(4'd15, 4'd3, 4'd15, 4'd7, 1'b1);
    repeat (6) try_pin(70);
  endtask

  // Hold the result side off while reports keep coming, so the input backs up.
  task automatic test_backpressure();
    send_idle  = 0;
    recv_stall = 0;
    -> hold_off_start;
    repeat (40) touch_key($urandom_range(0, KEY_NONE));
  endtask

  // Mostly code attempts and aimed touches, the rest random reports, drops and noise.
  task automatic test_random_traffic(input int send_pct, input int stall_pct);
    int start_count, pick;
    set_pin($urandom_range(9), $urandom_range(9), $urandom_range(9), $urandom_range(9), 1'b1);
    send_idle   = send_pct;
    recv_stall  = stall_pct;
    start_count = bytes_sent;
    while (bytes_sent - start_count < PHASE_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        try_pin(60);
      end else if (pick < 70) begin
        touch_key($urandom_range(0, KEY_NONE));
      end else if (pick < 78) begin
        push_byte(BYTE_REPORT);
        repeat (4) push_byte($urandom_range(255));
      end else if (pick < 88) begin
        drop_packet();
      end else if (pick < 94) begin
        repeat ($urandom_range(1, 6)) push_byte($urandom_range(255));
      end else begin
        // Broken report: cut short by a drop window, or followed by noise bytes.
        push_byte(BYTE_REPORT);
        repeat ($urandom_range(1, 3)) push_byte($urandom_range(255));
        if ($urandom_range(1) == 1) drop_packet();
        else repeat ($urandom_range(1, 4)) push_byte($urandom_range(255));
      end
    end
  endtask

  initial begin
    drop_left    = 0;
    report_phase = 0;
    digit_cnt    = 0;
    for (int i = 0; i < 3; i++) report_buf[i] = '0;
    for (int i = 0; i < PIN_LENGTH; i++) typed_digit[i] = '0;
    pin_code[0] = 4'd5;
    pin_code[1] = 4'd2;
    pin_code[2] = 4'd8;
    pin_code[3] = 4'd0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_extremes();
    test_framing();
    test_default_pin();
    test_digit_overflow();
    test_key_sweep();
    test_pin_registers();
    test_backpressure();
    test_random_traffic(0, 0);
    test_random_traffic(50, 0);
    test_random_traffic(0, 50);
    test_random_traffic(24, 24);
    settle();

    $display("touch_keypad_pin_lock_test: %0d bytes sent, %0d key presses checked, %0d reg writes",
             bytes_sent, n_checked, reg_writes);
    $display("touch_keypad_pin_lock_test: %0d unlocks, %0d rejects, %0d clears, input full %0d cycles",
             n_unlocks, n_rejects, n_clears, full_stalls);
    if (n_errors == 0 && pending_press.size() == 0)
      $display("touch_keypad_pin_lock_test: done, clean");
    else
      $display("touch_keypad_pin_lock_test: done, errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/tkpl_pkg.sv
design/tkpl_front.sv
design/tkpl_fifo.sv
design/tkpl_back.sv
design/touch_keypad_pin_lock.sv
sim/touch_keypad_pin_lock_test.sv
